### rtl/core/tccs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tccs_pkg
// Shared constants, types and build-time ROM contents of the table-assisted
// CORDIC sine/cosine generator.
// ---------------------------------------------------------------------------
package tccs_pkg;

    localparam int COARSE_BITS       = 7;
    localparam int FINE_BITS         = 9;
    localparam int ROTATION_COUNT    = 9;
    localparam int GUARD_BITS        = 4;
    localparam int EIGHTH_WAVE_TABLE = 1;

    localparam int STEPS1      = 1 << COARSE_BITS;
    localparam int STEPS2      = 1 << FINE_BITS;
    localparam int HALF_STEPS2 = STEPS2 / 2;
    localparam int BIG_SHIFT   = COARSE_BITS + 1 + EIGHTH_WAVE_TABLE;
    localparam int TABLE_SCALE = (EIGHTH_WAVE_TABLE != 0) ? 32767 * 4 : 65534;
    localparam int LOW_BIT     = 30 - COARSE_BITS - FINE_BITS - EIGHTH_WAVE_TABLE;

    // coarse word: {sin high bit, sin[15:0], cos[15:0]}
    localparam int COARSE_W = 33;
    // datapath: 17-bit magnitude, guard bits, headroom and sign
    localparam int DW       = 17 + GUARD_BITS + 3;
    localparam int OUT_W    = 16;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_B  = PI_Q60 >> (BIG_SHIFT + 1);

    typedef logic [STEPS1-1:0][COARSE_W-1:0]           t_coarse_rom;
    typedef logic [HALF_STEPS2-1:0][ROTATION_COUNT-2:0] t_rot_bank;

    // decoded phase
    typedef struct packed {
        logic [COARSE_BITS-1:0] s1;
        logic [FINE_BITS-1:0]   s2;
        logic [1:0]             quad;
        logic                   swap;
    } t_addr;

    // vector under rotation
    typedef struct packed {
        logic signed [DW-1:0]      x;
        logic signed [DW-1:0]      y;
        logic [ROTATION_COUNT-1:0] flags;
        logic [1:0]                quad;
        logic                      swap;
    } t_rot;

    // quadrant-corrected values before rounding
    typedef struct packed {
        logic signed [DW-1:0] ox;
        logic signed [DW-1:0] oy;
    } t_pre;

    // ---- build-time helpers (constant evaluation only) ----

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[sh +: 64];
    endfunction

    function automatic logic signed [63:0] atan_q60(input int k);
        logic signed [63:0] sum;
        logic signed [63:0] t;
        int n;
        sum = '0;
        if (k == 0) begin
            sum = signed'(PI_Q60 >> 2);
        end else begin
            for (n = 0; k * (2 * n + 1) <= 60; n++) begin
                t = signed'((64'd1 << (60 - k * (2 * n + 1))) / 64'(2 * n + 1));
                if (n[0]) sum = sum - t;
                else sum = sum + t;
            end
        end
        return sum;
    endfunction

    function automatic int calc_first_shift();
        int fs;
        int i;
        fs = 0;
        for (i = 0; i < 32; i++) begin
            if (fs == 0 && 64'(atan_q60(i)) < HALF_B) fs = i;
        end
        return fs;
    endfunction

    localparam int FIRST_SHIFT = calc_first_shift();

    // 1/gain of the micro-rotations, Newton iteration on 1/sqrt
    function automatic logic [63:0] calc_inv_gain();
        logic [63:0] sq;
        logic [63:0] r;
        logic [63:0] t;
        int j;
        int k;
        sq = ONE_Q60;
        for (j = 0; j < ROTATION_COUNT; j++) begin
            k = 2 * (FIRST_SHIFT + j);
            if (k < 64) sq = sq + (sq >> k);
        end
        r = ONE_Q60;
        for (j = 0; j < 8; j++) begin
            t = (64'd3 << 60) - mul_shift(sq, mul_shift(r, r, 60), 60);
            r = mul_shift(r, t, 61);
        end
        return r;
    endfunction

    // returns {cos, sin} in Q60 by Taylor series
    function automatic logic [127:0] sin_cos_q60(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] tc;
        logic [63:0] ts;
        logic [63:0] c;
        logic [63:0] s;
        logic signed [63:0] sc;
        logic signed [63:0] ss;
        int n;
        a2 = mul_shift(a, a, 60);
        tc = ONE_Q60;
        ts = a;
        sc = signed'(tc);
        ss = signed'(ts);
        for (n = 1; n < 30; n++) begin
            tc = mul_shift(tc, a2, 60) / 64'((2 * n - 1) * (2 * n));
            ts = mul_shift(ts, a2, 60) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sc = sc - signed'(tc);
                ss = ss - signed'(ts);
            end else begin
                sc = sc + signed'(tc);
                ss = ss + signed'(ts);
            end
        end
        c = (sc > 0) ? 64'(sc) : 64'd0;
        s = (ss > 0) ? 64'(ss) : 64'd0;
        return {c, s};
    endfunction

    function automatic t_coarse_rom build_coarse();
        t_coarse_rom rom;
        logic [127:0] cs;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] xv;
        logic [63:0] yv;
        int bound;
        int i;
        r = calc_inv_gain();
        bound = -1;
        for (i = 0; i < STEPS1; i++) begin
            a  = mul_shift(PI_Q60, 64'(2 * i + 1), BIG_SHIFT + 1);
            cs = sin_cos_q60(a);
            xv = mul_shift(mul_shift(cs[127:64], r, 60), 64'(TABLE_SCALE), 60);
            yv = mul_shift(mul_shift(cs[63:0], r, 60), 64'(TABLE_SCALE), 60);
            if (yv < 64'h10000) bound = i;
            rom[i] = {1'b0, yv[15:0], xv[15:0]};
        end
        for (i = 0; i < STEPS1; i++) begin
            if (EIGHTH_WAVE_TABLE != 0 && i > bound) rom[i][COARSE_W-1] = 1'b1;
        end
        return rom;
    endfunction

    // greedy arctangent signs, one half of the fine range per bank
    function automatic t_rot_bank build_rot_bank(input int bank);
        t_rot_bank rom;
        logic signed [63:0] atan_tab [32];
        logic signed [63:0] ang;
        logic [63:0] mag;
        logic [ROTATION_COUNT-1:0] flags;
        int i;
        int j;
        int num;
        int idx;
        for (i = 0; i < 32; i++) atan_tab[i] = atan_q60(i);
        for (i = 0; i < HALF_STEPS2; i++) begin
            num = 2 * (bank * HALF_STEPS2 + i) + 1 - STEPS2;
            mag = mul_shift(PI_Q60, 64'((num < 0) ? -num : num), FINE_BITS + BIG_SHIFT + 1);
            ang = (num < 0) ? -signed'(mag) : signed'(mag);
            flags = '0;
            for (j = 0; j < ROTATION_COUNT; j++) begin
                idx = FIRST_SHIFT + j;
                if (idx > 31) idx = 31;
                if (ang < 0) begin
                    ang = ang + atan_tab[idx];
                    flags[j] = 1'b1;
                end else begin
                    ang = ang - atan_tab[idx];
                end
            end
            rom[i] = flags[ROTATION_COUNT-1:1];
        end
        return rom;
    endfunction

    localparam t_coarse_rom COARSE_ROM = build_coarse();
    localparam t_rot_bank   ROT_ROM_LO = build_rot_bank(0);
    localparam t_rot_bank   ROT_ROM_HI = build_rot_bank(1);

endpackage
`default_nettype wire

### rtl/core/tccs_lookup.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tccs_lookup
// Phase decode (quadrant, mirror, table indexes) and the coarse and
// rotation-sign ROM reads. Two register stages.
// ---------------------------------------------------------------------------
module tccs_lookup import tccs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_phase,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_rot             o_data
);

    logic  r_a_valid;
    t_addr r_a;
    t_addr n_a;
    logic  r_b_valid;
    t_rot  r_b;
    t_rot  n_b;
    logic  w_a_ready;
    logic  w_b_ready;

    logic [COARSE_W-1:0]       w_entry;
    logic [ROTATION_COUNT-2:0] w_signs;
    logic [16:0]               w_xm;
    logic [16:0]               w_ym;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;
    assign o_valid   = r_b_valid;
    assign o_data    = r_b;

    always_comb begin
        n_a.quad = i_phase[31:30];
        n_a.s1   = i_phase[LOW_BIT + FINE_BITS +: COARSE_BITS];
        n_a.s2   = i_phase[LOW_BIT +: FINE_BITS];
        n_a.swap = 1'b0;
        if (EIGHTH_WAVE_TABLE != 0) begin
            // upper half of each quadrant mirrors the angle; sin/cos swap when bits 29 and 30 differ
            if (i_phase[29]) begin
                n_a.s1 = ~n_a.s1;
                n_a.s2 = ~n_a.s2;
            end
            n_a.swap = i_phase[29] ^ i_phase[30];
        end
    end

    always_comb begin
        w_entry = COARSE_ROM[r_a.s1];
        w_signs = r_a.s2[FINE_BITS-1] ? ROT_ROM_HI[r_a.s2[FINE_BITS-2:0]]
                                      : ROT_ROM_LO[r_a.s2[FINE_BITS-2:0]];
        w_xm    = {1'(EIGHTH_WAVE_TABLE), w_entry[15:0]};
        w_ym    = {w_entry[COARSE_W-1], w_entry[31:16]};
        n_b.x     = signed'(DW'(w_xm) << GUARD_BITS);
        n_b.y     = signed'(DW'(w_ym) << GUARD_BITS);
        n_b.flags = {w_signs, ~r_a.s2[FINE_BITS-1]};
        n_b.quad  = r_a.quad;
        n_b.swap  = r_a.swap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) r_a_valid <= i_valid;
            if (w_b_ready) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) r_a <= n_a;
        if (w_b_ready && r_a_valid) r_b <= n_b;
    end

endmodule
`default_nettype wire

### rtl/core/tccs_rotator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tccs_rotator
// Shift-add micro-rotations, one register stage per rotation.
// ---------------------------------------------------------------------------
module tccs_rotator import tccs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_rot i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rot      o_data
);

    logic r_valid [ROTATION_COUNT];
    t_rot r_data  [ROTATION_COUNT];
    logic w_valid [ROTATION_COUNT+1];
    t_rot w_data  [ROTATION_COUNT+1];
    logic w_ready [ROTATION_COUNT+1];

    assign w_valid[0]              = i_valid;
    assign w_data[0]               = i_data;
    assign w_ready[ROTATION_COUNT] = i_ready;
    assign o_ready                 = w_ready[0];
    assign o_valid                 = w_valid[ROTATION_COUNT];
    assign o_data                  = w_data[ROTATION_COUNT];

    for (genvar g = 0; g < ROTATION_COUNT; g++) begin : g_stage
        logic signed [DW-1:0] w_sx;
        logic signed [DW-1:0] w_sy;
        t_rot                 n_data;

        assign w_ready[g]     = !r_valid[g] || w_ready[g+1];
        assign w_valid[g+1]   = r_valid[g];
        assign w_data[g+1]    = r_data[g];

        always_comb begin
            w_sx   = w_data[g].x >>> (FIRST_SHIFT + g);
            w_sy   = w_data[g].y >>> (FIRST_SHIFT + g);
            n_data = w_data[g];
            // flag set: clockwise step
            if (w_data[g].flags[g]) begin
                n_data.x = w_data[g].x + w_sy;
                n_data.y = w_data[g].y - w_sx;
            end else begin
                n_data.x = w_data[g].x - w_sy;
                n_data.y = w_data[g].y + w_sx;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (w_ready[g]) begin
                r_valid[g] <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[g] && w_valid[g]) r_data[g] <= n_data;
        end
    end

endmodule
`default_nettype wire

### rtl/core/tccs_output.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tccs_output
// Quadrant swap and negation, guard-bit removal, rounding and saturation.
// Two register stages; the last one is the output register.
// ---------------------------------------------------------------------------
module tccs_output import tccs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_rot               i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [OUT_W-1:0] o_cos_out,
    output logic signed [OUT_W-1:0] o_sin_out
);

    localparam logic signed [DW:0] SAT_HI = (DW+1)'(32767);
    localparam logic signed [DW:0] SAT_LO = -(DW+1)'(32768);

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [DW-1:0] v);
        logic signed [DW:0] t;
        t = {v[DW-1], v} + (DW+1)'(1);
        t = t >>> 1;
        if (t > SAT_HI) return OUT_W'(SAT_HI);
        if (t < SAT_LO) return OUT_W'(SAT_LO);
        return t[OUT_W-1:0];
    endfunction

    logic                    r_a_valid;
    t_pre                    r_a;
    t_pre                    n_a;
    logic                    r_b_valid;
    logic signed [OUT_W-1:0] r_cos;
    logic signed [OUT_W-1:0] r_sin;
    logic                    w_a_ready;
    logic                    w_b_ready;

    logic signed [DW-1:0] w_src_x;
    logic signed [DW-1:0] w_src_y;
    logic                 w_neg_x;
    logic                 w_neg_y;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;
    assign o_valid   = r_b_valid;
    assign o_cos_out = r_cos;
    assign o_sin_out = r_sin;

    always_comb begin
        if (EIGHTH_WAVE_TABLE != 0) begin
            w_src_x = i_data.swap ? i_data.y : i_data.x;
            w_src_y = i_data.swap ? i_data.x : i_data.y;
            w_neg_x = (i_data.quad == QUAD_1) || (i_data.quad == QUAD_2);
            w_neg_y = (i_data.quad == QUAD_2) || (i_data.quad == QUAD_3);
        end else begin
            case (i_data.quad)
                QUAD_0: begin
                    w_src_x = i_data.x; w_neg_x = 1'b0;
                    w_src_y = i_data.y; w_neg_y = 1'b0;
                end
                QUAD_1: begin
                    w_src_x = i_data.y; w_neg_x = 1'b1;
                    w_src_y = i_data.x; w_neg_y = 1'b0;
                end
                QUAD_2: begin
                    w_src_x = i_data.x; w_neg_x = 1'b1;
                    w_src_y = i_data.y; w_neg_y = 1'b1;
                end
                default: begin
                    w_src_x = i_data.y; w_neg_x = 1'b0;
                    w_src_y = i_data.x; w_neg_y = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        if (EIGHTH_WAVE_TABLE != 0) begin
            // shift first, then negate
            n_a.ox = w_neg_x ? -(w_src_x >>> (GUARD_BITS + 1)) : (w_src_x >>> (GUARD_BITS + 1));
            n_a.oy = w_neg_y ? -(w_src_y >>> (GUARD_BITS + 1)) : (w_src_y >>> (GUARD_BITS + 1));
        end else begin
            // negate first, then shift
            n_a.ox = (w_neg_x ? -w_src_x : w_src_x) >>> GUARD_BITS;
            n_a.oy = (w_neg_y ? -w_src_y : w_src_y) >>> GUARD_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) r_a_valid <= i_valid;
            if (w_b_ready) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) r_a <= n_a;
        if (w_b_ready && r_a_valid) begin
            r_cos <= round_sat(r_a.ox);
            r_sin <= round_sat(r_a.oy);
        end
    end

endmodule
`default_nettype wire

### rtl/core/table_cordic_sine_cosine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// table_cordic_sine_cosine
// Table-assisted CORDIC sine/cosine: coarse ROM lookup, shift-add
// micro-rotations steered by a sign ROM, quadrant fix-up and rounding.
// ---------------------------------------------------------------------------
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+-------------------------------
//  phase in | i_in_valid  | o_in_ready  | i_phase [31:0] unsigned
//  result   | o_out_valid | i_out_ready | o_cos_out, o_sin_out [15:0] signed
//
//  One transaction per cycle sustained while the result side is not stalled.
//  Stages: two lookup stages, one stage per micro-rotation, two
//  output stages. Each stage has its own valid bit and loads when it is
//  empty or its successor moves, so bubbles collapse during a stall.
//  Synchronous active-low reset clears the valid bits only; ROMs are
//  constant logic and need no fill.
// ---------------------------------------------------------------------------
module table_cordic_sine_cosine import tccs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [31:0]        i_phase,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [OUT_W-1:0] o_cos_out,
    output logic signed [OUT_W-1:0] o_sin_out
);

    logic w_lk_valid;
    logic w_lk_ready;
    t_rot w_lk_data;
    logic w_rot_valid;
    logic w_rot_ready;
    t_rot w_rot_data;

    tccs_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_phase (i_phase),
        .o_valid (w_lk_valid),
        .i_ready (w_lk_ready),
        .o_data  (w_lk_data)
    );

    tccs_rotator u_rotator (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lk_valid),
        .o_ready (w_lk_ready),
        .i_data  (w_lk_data),
        .o_valid (w_rot_valid),
        .i_ready (w_rot_ready),
        .o_data  (w_rot_data)
    );

    tccs_output u_output (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_rot_valid),
        .o_ready   (w_rot_ready),
        .i_data    (w_rot_data),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_cos_out (o_cos_out),
        .o_sin_out (o_sin_out)
    );

endmodule
`default_nettype wire

### rtl/core/tccs_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tccs_checker
// Port-level checks of the sine/cosine generator, bound to the top level.
// ---------------------------------------------------------------------------
module tccs_checker import tccs_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [31:0]        i_phase,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [OUT_W-1:0] o_cos_out,
    input wire logic signed [OUT_W-1:0] o_sin_out
);

    // a waiting phase stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_phase))
        else $error("phase transaction changed while waiting");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_cos_out) && $stable(o_sin_out))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // with the output free, the pipeline must take a new transaction
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled with output free");

endmodule

bind table_cordic_sine_cosine tccs_checker u_tccs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_phase     (i_phase),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_cos_out   (o_cos_out),
    .o_sin_out   (o_sin_out)
);
`default_nettype wire

### tb/tb_table_cordic_sine_cosine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_table_cordic_sine_cosine
// Self-checking bench for the table-assisted CORDIC sine/cosine block. The
// bench rebuilds the coarse and rotation-sign ROMs at time zero with its own
// fixed-point code. Each accepted phase is run through a bit-exact predictor,
// and the expected pair is queued. Results are compared in order. Stimulus is
// a short table of edge phases, then random phases. The sender works in
// bursts with gaps, and the receiver stalls in changing patterns.
// ---------------------------------------------------------------------------
module tb_table_cordic_sine_cosine;
    import tccs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int LATENCY      = 4 + ROTATION_COUNT;

    typedef struct packed {
        logic signed [OUT_W-1:0] cos_v;
        logic signed [OUT_W-1:0] sin_v;
    } t_trig_pair;

    // phases at quadrant/octant seams, index limits and the fine sign boundary
    localparam logic [31:0] EDGE_PHASES [24] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h8000_0000,
        32'hC000_0000, 32'h2000_0000, 32'h1FFF_FFFF, 32'h3FFF_FFFF,
        32'h5FFF_FFFF, 32'h6000_0000, 32'h7FFF_FFFF, 32'h9FFF_FFFF,
        32'hA000_0000, 32'hBFFF_FFFF, 32'hE000_0000, 32'h0000_1FFF,
        32'h0000_2000, 32'h003F_E000, 32'h0020_0000, 32'h001F_E000,
        32'h1FC0_0000, 32'h0040_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic [31:0]             i_phase     = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_cos_out;
    logic signed [OUT_W-1:0] o_sin_out;

    // predictor state: ROM images and derived constants
    logic [31:0]               coarse_words [STEPS1];
    logic [ROTATION_COUNT-2:0] turn_dirs    [STEPS2];
    logic signed [63:0]        atan_steps   [32];
    int                        first_k;
    int                        sin_bound;

    t_trig_pair expected_pairs [$];
    t_trig_pair head_pair;
    bit         rst_done = 1'b0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    int         ready_mode = 0;
    int         ready_hold = 0;
    int         stall_left = 0;

    table_cordic_sine_cosine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_phase     (i_phase),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cos_out   (o_cos_out),
        .o_sin_out   (o_sin_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // (a * b) >> sh, low 64 bits
    function automatic logic [63:0] q_mul_shr(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return p[63:0];
    endfunction

    task automatic build_sine_tables();
        logic [63:0] half_b;
        logic [63:0] sq;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] tc;
        logic [63:0] ts;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] xv;
        logic [63:0] yv;
        logic [63:0] mag;
        logic signed [63:0] sc;
        logic signed [63:0] ss;
        logic signed [63:0] term;
        logic signed [63:0] ang;
        logic [ROTATION_COUNT-1:0] dirs;
        int i;
        int j;
        int n;
        int num;
        int idx;

        atan_steps[0] = $signed(PI_Q60 >> 2);
        for (i = 1; i < 32; i++) begin
            atan_steps[i] = '0;
            for (n = 0; i * (2 * n + 1) <= 60; n++) begin
                term = $signed((64'd1 << (60 - i * (2 * n + 1))) / 64'(2 * n + 1));
                atan_steps[i] = n[0] ? atan_steps[i] - term : atan_steps[i] + term;
            end
        end
        half_b = PI_Q60 >> (BIG_SHIFT + 1);
        first_k = 0;
        for (i = 0; i < 32; i++) begin
            if (first_k == 0 && 64'(atan_steps[i]) < half_b) first_k = i;
        end

        // inverse CORDIC gain by Newton iteration on 1/sqrt
        sq = ONE_Q60;
        for (j = 0; j < ROTATION_COUNT; j++) begin
            if (2 * (first_k + j) < 64) sq = sq + (sq >> (2 * (first_k + j)));
        end
        r = ONE_Q60;
        for (n = 0; n < 8; n++) begin
            t = (64'd3 << 60) - q_mul_shr(sq, q_mul_shr(r, r, 60), 60);
            r = q_mul_shr(r, t, 61);
        end

        sin_bound = -1;
        for (i = 0; i < STEPS1; i++) begin
            a  = q_mul_shr(PI_Q60, 64'(2 * i + 1), BIG_SHIFT + 1);
            a2 = q_mul_shr(a, a, 60);
            tc = ONE_Q60;
            ts = a;
            sc = $signed(tc);
            ss = $signed(ts);
            for (n = 1; n < 30; n++) begin
                tc = q_mul_shr(tc, a2, 60) / 64'((2 * n - 1) * (2 * n));
                ts = q_mul_shr(ts, a2, 60) / 64'((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    sc = sc - $signed(tc);
                    ss = ss - $signed(ts);
                end else begin
                    sc = sc + $signed(tc);
                    ss = ss + $signed(ts);
                end
            end
            c  = (sc > 0) ? 64'(sc) : 64'd0;
            s  = (ss > 0) ? 64'(ss) : 64'd0;
            xv = q_mul_shr(q_mul_shr(c, r, 60), 64'(TABLE_SCALE), 60);
            yv = q_mul_shr(q_mul_shr(s, r, 60), 64'(TABLE_SCALE), 60);
            if (yv < 64'h10000) sin_bound = i;
            coarse_words[i] = {yv[15:0], xv[15:0]};
        end

        // greedy arctangent decomposition of each fine offset
        for (i = 0; i < STEPS2; i++) begin
            num = 2 * i + 1 - STEPS2;
            mag = q_mul_shr(PI_Q60, 64'((num < 0) ? -num : num), FINE_BITS + BIG_SHIFT + 1);
            ang = (num < 0) ? -$signed(mag) : $signed(mag);
            dirs = '0;
            for (j = 0; j < ROTATION_COUNT; j++) begin
                idx = (first_k + j > 31) ? 31 : first_k + j;
                if (ang < 0) begin
                    ang = ang + atan_steps[idx];
                    dirs[j] = 1'b1;
                end else begin
                    ang = ang - atan_steps[idx];
                end
            end
            turn_dirs[i] = dirs[ROTATION_COUNT-1:1];
        end
    endtask

    function automatic t_trig_pair predict_cos_sin(input logic [31:0] ph);
        logic [1:0]                quad;
        logic [COARSE_BITS-1:0]    c_idx;
        logic [FINE_BITS-1:0]      f_idx;
        logic [31:0]               word;
        logic [ROTATION_COUNT-1:0] dirs;
        logic signed [63:0]        x;
        logic signed [63:0]        y;
        logic signed [63:0]        sx;
        logic signed [63:0]        sy;
        logic signed [63:0]        ox;
        logic signed [63:0]        oy;
        logic                      swap;
        t_trig_pair                res;
        int                        i;

        quad  = ph[31:30];
        c_idx = ph[LOW_BIT + FINE_BITS +: COARSE_BITS];
        f_idx = ph[LOW_BIT +: FINE_BITS];
        if (EIGHTH_WAVE_TABLE != 0 && ph[29]) begin
            c_idx = ~c_idx;
            f_idx = ~f_idx;
        end
        word = coarse_words[c_idx];
        x = {48'd0, word[15:0]};
        y = {48'd0, word[31:16]};
        if (EIGHTH_WAVE_TABLE != 0) begin
            // restore the implied 17th bits
            x = x | 64'h10000;
            if (int'(c_idx) > sin_bound) y = y | 64'h10000;
        end
        x = x <<< GUARD_BITS;
        y = y <<< GUARD_BITS;

        dirs = {turn_dirs[f_idx], (f_idx < HALF_STEPS2)};
        for (i = 0; i < ROTATION_COUNT; i++) begin
            sx = x >>> (first_k + i);
            sy = y >>> (first_k + i);
            if (dirs[i]) begin
                x = x + sy;
                y = y - sx;
            end else begin
                x = x - sy;
                y = y + sx;
            end
        end

        if (EIGHTH_WAVE_TABLE != 0) begin
            swap = ph[29] ^ quad[0];
            ox = (swap ? y : x) >>> (GUARD_BITS + 1);
            oy = (swap ? x : y) >>> (GUARD_BITS + 1);
            if (quad == QUAD_1 || quad == QUAD_2) ox = -ox;
            if (quad == QUAD_2 || quad == QUAD_3) oy = -oy;
        end else begin
            case (quad)
                QUAD_0: begin ox = x;  oy = y;  end
                QUAD_1: begin ox = -y; oy = x;  end
                QUAD_2: begin ox = -x; oy = -y; end
                default: begin ox = y; oy = -x; end
            endcase
            ox = ox >>> GUARD_BITS;
            oy = oy >>> GUARD_BITS;
        end
        ox = (ox + 1) >>> 1;
        oy = (oy + 1) >>> 1;
        res.cos_v = (ox > 32767) ? 16'sh7FFF : (ox < -32768) ? 16'sh8000 : ox[15:0];
        res.sin_v = (oy > 32767) ? 16'sh7FFF : (oy < -32768) ? 16'sh8000 : oy[15:0];
        return res;
    endfunction

    // one phase transaction; bursts of back-to-back items separated by gaps
    task automatic send_phase(input logic [31:0] ph);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_phase    <= ph;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_pairs.push_back(predict_cos_sin(ph));
        burst_left--;
    endtask

    // hold the input off until the pipeline has drained
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pairs.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic note_mismatch(input string what, input t_trig_pair want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected cos=%0d sin=%0d, got cos=%0d sin=%0d",
                     $realtime, what, want.cos_v, want.sin_v, o_cos_out, o_sin_out);
    endtask

    // stimulus
    initial begin
        logic [31:0] ph;
        int k;
        build_sine_tables();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        foreach (EDGE_PHASES[k]) send_phase(EDGE_PHASES[k]);
        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            case ($urandom_range(0, 9))
                // near an octant seam from either side
                0, 1: begin
                    ph = $urandom_range(0, 16'h3FFF);
                    if ($urandom_range(0, 1) == 1) ph = 32'h1FFF_FFFF - ph;
                    ph[31:29] = 3'($urandom_range(0, 7));
                end
                // exact coarse/fine grid points
                2: ph = $urandom & ~32'((1 << LOW_BIT) - 1);
                default: ph = $urandom;
            endcase
            send_phase(ph);
            if (k == RANDOM_ITEMS / 2) wait_drained();
        end

        i_in_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // receiver back-pressure: the pattern changes after a random hold
    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(50, 300);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left == 0) begin
                    i_out_ready <= 1'b1;
                    stall_left = $urandom_range(5, 20);
                end else begin
                    i_out_ready <= 1'b0;
                    stall_left--;
                end
            end
        endcase
    end

    // result check
    always @(posedge i_clk) begin
        if (rst_done && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_pairs.size() == 0) begin
                note_mismatch("unexpected transaction", '0);
            end else begin
                head_pair = expected_pairs.pop_front();
                if (o_cos_out !== head_pair.cos_v || o_sin_out !== head_pair.sin_v)
                    note_mismatch("cos/sin", head_pair);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

### table_cordic_sine_cosine.f
rtl/core/tccs_pkg.sv
rtl/core/tccs_lookup.sv
rtl/core/tccs_rotator.sv
rtl/core/tccs_output.sv
rtl/core/table_cordic_sine_cosine.sv
rtl/core/tccs_checker.sv
tb/tb_table_cordic_sine_cosine.sv
